// ----- hw/rtl/ple_pkg.sv -----
// package for the positional list engine
// codes, field widths and state encoding; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

   // default number of list entries
   localparam int CAPACITY_DEF = 32;

   // field widths
   localparam int VAL_W = 32;
   localparam int CNT_W = 7;
   localparam int IDX_W = 6;
   localparam int FUNC_W = 2;
   localparam int MODE_W = 2;
   localparam int STAT_W = 2;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

   // placement codes
   localparam logic [MODE_W-1:0] MODE_BEGIN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AT    = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd3;

   // sequencer states, one-hot
   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_INS_SHIFT = 8'b0000_0010,
      S_INS_DRAIN = 8'b0000_0100,
      S_INS_PUT   = 8'b0000_1000,
      S_DEL_SHIFT = 8'b0001_0000,
      S_DEL_DRAIN = 8'b0010_0000,
      S_READ      = 8'b0100_0000,
      S_RESP      = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/positional_list_engine_top.sv -----
// positional list engine top level: list store, shift sequencer, result register
// depends on ple_pkg
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered list of signed 32-bit values kept in one synchronous memory
// of CAPACITY entries (entry 0 is the head). One request item is worked on at a
// time. An insert or delete at the tail, any request on an empty list, a
// single-entry delete and a rejected request go from idle straight to the status
// state. An insert before slot k (zero-based) moves count-k entries up, one
// read and one write of the memory port pair per cycle, then passes the drain
// and put states; a delete of slot k moves count-k-1 entries down, then passes
// the drain state. A read-out emits one element per cycle while the result side
// does not stall, each from the registered memory read. The next request is
// taken as soon as the sequencer is back in idle, while the last result may
// still sit in the output register. The memory needs no clearing pass after
// reset: only entries below the count are ever read.
module positional_list_engine_top #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // request channel
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [ple_pkg::FUNC_W-1:0]       req_func,
   input  wire  [ple_pkg::MODE_W-1:0]       req_place_mode,
   input  wire  [ple_pkg::CNT_W-1:0]        req_position,
   input  wire  signed [ple_pkg::VAL_W-1:0] req_value,
   // result channel
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [ple_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [ple_pkg::VAL_W-1:0] rsp_element,
   output logic [ple_pkg::IDX_W-1:0]        rsp_element_index,
   output logic [ple_pkg::CNT_W-1:0]        rsp_entry_total,
   output logic                             rsp_last
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = ple_pkg::CNT_W;
   localparam int VW = ple_pkg::VAL_W;

   // list memory and its read data register
   logic signed [VW-1:0] store_ff [CAPACITY];
   logic signed [VW-1:0] rdata_ff;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic signed [VW-1:0] wr_data;

   // sequencer state
   ple_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [AW-1:0]        stop_ff, stop_in;
   logic signed [VW-1:0] value_ff, value_in;
   logic [ple_pkg::STAT_W-1:0] status_ff, status_in;
   logic                 wb_valid_ff, wb_valid_in;
   logic [AW-1:0]        wb_addr_ff, wb_addr_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ple_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic signed [VW-1:0]       rsp_element_ff, rsp_element_in;
   logic [ple_pkg::IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [CW-1:0]              rsp_total_ff, rsp_total_in;
   logic                       rsp_last_ff, rsp_last_in;

   // decode of the current count and request position
   logic          out_free;
   logic          cnt_full, cnt_zero, cnt_one;
   logic          ins_pos_ok, del_pos_ok;
   logic [AW-1:0] pos_idx, last_idx, cnt_idx;
   logic [AW-1:0] tgt;
   logic          tgt_ok;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cnt_full   = count_ff >= CW'(CAPACITY);
   assign cnt_zero   = count_ff == '0;
   assign cnt_one    = count_ff == CW'(1);
   assign ins_pos_ok = (req_position != '0) && (req_position <= count_ff + CW'(1));
   assign del_pos_ok = (req_position != '0) && (req_position <= count_ff);
   assign pos_idx    = AW'(req_position - CW'(1));
   assign last_idx   = AW'(count_ff - CW'(1));
   assign cnt_idx    = AW'(count_ff);

   // target slot of an insert or delete
   always_comb begin
      tgt    = '0;
      tgt_ok = 1'b1;
      case (req_place_mode)
         ple_pkg::MODE_BEGIN: tgt = '0;
         ple_pkg::MODE_END: begin
            tgt = (req_func == ple_pkg::FUNC_INSERT) ? cnt_idx : last_idx;
         end
         ple_pkg::MODE_AT: begin
            tgt    = pos_idx;
            tgt_ok = (req_func == ple_pkg::FUNC_INSERT) ? ins_pos_ok : del_pos_ok;
         end
         default: tgt_ok = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      stop_in        = stop_ff;
      value_in       = value_ff;
      status_in      = status_ff;
      wb_valid_in    = 1'b0;
      wb_addr_in     = wb_addr_ff;
      rd_en          = 1'b0;
      rd_addr        = ptr_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_last_in    = rsp_last_ff;

      // write back the entry read in the previous shift cycle
      if (wb_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = wb_addr_ff;
         wr_data = rdata_ff;
      end

      case (state_ff)
         ple_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  ple_pkg::FUNC_INSERT: begin
                     state_in = ple_pkg::S_RESP;
                     if (cnt_full) begin
                        status_in = ple_pkg::STATUS_FULL;
                     end else if (cnt_zero || (tgt_ok && tgt == cnt_idx)) begin
                        // append at the tail, nothing to move
                        status_in = ple_pkg::STATUS_OK;
                        wr_en     = 1'b1;
                        wr_addr   = cnt_idx;
                        wr_data   = req_value;
                        count_in  = count_ff + CW'(1);
                     end else if (!tgt_ok) begin
                        status_in = ple_pkg::STATUS_INVALID;
                     end else begin
                        status_in = ple_pkg::STATUS_OK;
                        ptr_in    = last_idx;
                        stop_in   = tgt;
                        value_in  = req_value;
                        state_in  = ple_pkg::S_INS_SHIFT;
                     end
                  end
                  ple_pkg::FUNC_DELETE: begin
                     state_in = ple_pkg::S_RESP;
                     if (cnt_zero) begin
                        status_in = ple_pkg::STATUS_EMPTY;
                     end else if (cnt_one || (tgt_ok && tgt == last_idx)) begin
                        // drop the tail entry
                        status_in = ple_pkg::STATUS_OK;
                        count_in  = count_ff - CW'(1);
                     end else if (!tgt_ok) begin
                        status_in = ple_pkg::STATUS_INVALID;
                     end else begin
                        status_in = ple_pkg::STATUS_OK;
                        ptr_in    = tgt + AW'(1);
                        stop_in   = last_idx;
                        state_in  = ple_pkg::S_DEL_SHIFT;
                     end
                  end
                  ple_pkg::FUNC_READ: begin
                     if (cnt_zero) begin
                        status_in = ple_pkg::STATUS_EMPTY;
                        state_in  = ple_pkg::S_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        ptr_in   = '0;
                        state_in = ple_pkg::S_READ;
                     end
                  end
                  default: state_in = ple_pkg::S_IDLE;
               endcase
            end
         end
         // move entries up, tail first, down to the target slot
         ple_pkg::S_INS_SHIFT: begin
            rd_en       = 1'b1;
            rd_addr     = ptr_ff;
            wb_valid_in = 1'b1;
            wb_addr_in  = ptr_ff + AW'(1);
            if (ptr_ff == stop_ff) begin
               state_in = ple_pkg::S_INS_DRAIN;
            end else begin
               ptr_in = ptr_ff - AW'(1);
            end
         end
         ple_pkg::S_INS_DRAIN: begin
            state_in = ple_pkg::S_INS_PUT;
         end
         ple_pkg::S_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = stop_ff;
            wr_data  = value_ff;
            count_in = count_ff + CW'(1);
            state_in = ple_pkg::S_RESP;
         end
         // move entries down, from just past the target to the tail
         ple_pkg::S_DEL_SHIFT: begin
            rd_en       = 1'b1;
            rd_addr     = ptr_ff;
            wb_valid_in = 1'b1;
            wb_addr_in  = ptr_ff - AW'(1);
            if (ptr_ff == stop_ff) begin
               state_in = ple_pkg::S_DEL_DRAIN;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         ple_pkg::S_DEL_DRAIN: begin
            count_in = count_ff - CW'(1);
            state_in = ple_pkg::S_RESP;
         end
         // read-out: one element per free output slot, next read issued alongside
         ple_pkg::S_READ: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ple_pkg::STATUS_OK;
               rsp_element_in = rdata_ff;
               rsp_index_in   = ple_pkg::IDX_W'(ptr_ff);
               rsp_total_in   = count_ff;
               rsp_last_in    = ptr_ff == last_idx;
               if (ptr_ff == last_idx) begin
                  state_in = ple_pkg::S_IDLE;
               end else begin
                  ptr_in   = ptr_ff + AW'(1);
                  rd_en    = 1'b1;
                  rd_addr  = ptr_ff + AW'(1);
               end
            end
         end
         // single status item for insert, delete and empty read-out
         ple_pkg::S_RESP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_element_in = '0;
               rsp_index_in   = '0;
               rsp_total_in   = count_ff;
               rsp_last_in    = 1'b1;
               state_in       = ple_pkg::S_IDLE;
            end
         end
         default: state_in = ple_pkg::S_IDLE;
      endcase
   end

   // list memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= store_ff[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ple_pkg::S_IDLE;
         count_ff     <= '0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      stop_ff        <= stop_in;
      value_ff       <= value_in;
      status_ff      <= status_in;
      wb_addr_ff     <= wb_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // ports
   assign req_stall         = state_ff != ple_pkg::S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element       = rsp_element_ff;
   assign rsp_element_index = rsp_index_ff;
   assign rsp_entry_total   = rsp_total_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef SYNTHESIS
   // the count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // shift write-backs stay inside the list or at the slot just past its tail
   a_wb_bound: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (CW'(wb_addr_ff) <= count_ff))
      else $error("shift write-back beyond the list");

   // read-out pointer stays below the count
   a_read_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ple_pkg::S_READ) |-> (CW'(ptr_ff) < count_ff))
      else $error("read-out pointer beyond the list");

   // an item that is not the last one comes from a read-out and is not the final element
   a_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |->
         ((CW'(rsp_index_ff) + CW'(1)) < rsp_total_ff))
      else $error("non-final item with a final index");
`endif

endmodule

`default_nettype wire
